>>> hw/rtl/swrs_pkg.sv
// Shared types for the sliding window rank statistics block.
package swrs_pkg;

  typedef struct packed {
    logic first;
    logic last;
  } swrs_cell_pos_t;

endpackage

>>> hw/rtl/swrs_if.sv
// Stream interfaces carrying sample words in and statistics words out.
interface swrs_in_if #(
  parameter int SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swrs_out_if #(
  parameter int SampleBits = 16,
  parameter int SumBits    = 19
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] window_max;
  logic signed [SampleBits-1:0] window_min;
  logic signed [SampleBits-1:0] window_median;
  logic signed [SumBits-1:0]    window_sum;

  modport source (output valid, output window_max, output window_min,
                  output window_median, output window_sum, input ready);
  modport sink   (input valid, input window_max, input window_min,
                  input window_median, input window_sum, output ready);
endinterface

>>> hw/rtl/sliding_window_rank_stats.sv
// Top level of the sliding window rank statistics block.
// Each accepted sample word's statistics word is registered and offered in the cycle after it is accepted.
// Throughput: one sample word per cycle unless the output stalls; the sorted cell row updates all slots at once.
// The first WINDOW-1 samples after reset yield no word.
// Reset fills the sorted window with the minimum sample value and clears count and sum.
module sliding_window_rank_stats #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swrs_in_if.sink     in_i,
  swrs_out_if.source  out_o
);
  import swrs_pkg::*;

  localparam int SumBits   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int CntBits   = $clog2(WINDOW + 1);
  localparam int MedianIdx = (WINDOW - 1) / 2;
  localparam logic signed [SAMPLE_BITS-1:0] MinValue = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [CntBits-1:0] FullCount = CntBits'(WINDOW);

  logic signed [SAMPLE_BITS-1:0] arrival_q [WINDOW];
  logic signed [SAMPLE_BITS-1:0] sorted_w  [WINDOW];
  logic [CntBits-1:0]            fill_q, fill_d;
  logic signed [SumBits-1:0]     sum_q, sum_d;
  logic                          accept, full;
  logic signed [SAMPLE_BITS-1:0] leaver;
  logic                          out_valid_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (fill_q == FullCount);
  assign leaver     = full ? arrival_q[0] : MinValue;
  assign fill_d     = full ? fill_q : fill_q + CntBits'(1);
  assign sum_d      = sum_q + SumBits'(in_i.sample)
                      - (full ? SumBits'(arrival_q[0]) : SumBits'(0));

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swrs_cell_pos_t                pos;
    logic signed [SAMPLE_BITS-1:0] prev, next;

    assign pos.first = (i == 0);
    assign pos.last  = (i == WINDOW - 1);
    if (i == 0) begin : g_lo
      assign prev = sorted_w[i];
    end else begin : g_lo
      assign prev = sorted_w[i-1];
    end
    if (i == WINDOW - 1) begin : g_hi
      assign next = sorted_w[i];
    end else begin : g_hi
      assign next = sorted_w[i+1];
    end

    swrs_sort_cell #(.SampleBits(SAMPLE_BITS)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .pos_i      (pos),
      .leaver_i   (leaver),
      .newcomer_i (in_i.sample),
      .prev_i     (prev),
      .next_i     (next),
      .value_o    (sorted_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < WINDOW - 1; k++) begin
        arrival_q[k] <= arrival_q[k+1];
      end
      arrival_q[WINDOW-1] <= in_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        sum_q       <= sum_d;
        out_valid_q <= (fill_d == FullCount);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.window_max    = sorted_w[WINDOW-1];
  assign out_o.window_min    = sorted_w[0];
  assign out_o.window_median = sorted_w[MedianIdx];
  assign out_o.window_sum    = sum_q;
endmodule

>>> hw/rtl/swrs_sort_cell.sv
// One slot of the sorted window: drops the leaving value and inserts the new one.
module swrs_sort_cell #(
  parameter int SampleBits = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  swrs_pkg::swrs_cell_pos_t     pos_i,
  input  logic signed [SampleBits-1:0] leaver_i,
  input  logic signed [SampleBits-1:0] newcomer_i,
  input  logic signed [SampleBits-1:0] prev_i,
  input  logic signed [SampleBits-1:0] next_i,
  output logic signed [SampleBits-1:0] value_o
);
  import swrs_pkg::*;

  localparam logic signed [SampleBits-1:0] MinValue = {1'b1, {(SampleBits-1){1'b0}}};

  logic signed [SampleBits-1:0] value_q, value_d;
  logic signed [SampleBits-1:0] t_prev, t_cur;

  always_comb begin
    t_prev = (prev_i < leaver_i) ? prev_i : value_q;
    t_cur  = (value_q < leaver_i) ? value_q : next_i;
    if (!pos_i.last && (t_cur <= newcomer_i)) begin
      value_d = t_cur;
    end else if (pos_i.first || (t_prev <= newcomer_i)) begin
      value_d = newcomer_i;
    end else begin
      value_d = t_prev;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= MinValue;
    end else if (en_i) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;
endmodule
